// ----- src/a2ab_pkg.sv -----
// shared types and constants for the length-prefix to start-code converter
// no dependencies; imported by every module of the block
`default_nettype none

package a2ab_pkg;

  // fixed field widths
  localparam int BYTE_W   = 8;
  localparam int PREFIX_W = 3;
  localparam int BYTES_W  = 32;
  localparam int LEN_W    = 32;

  // prefix size limits and reset value
  localparam logic [PREFIX_W-1:0] PREFIX_MIN   = 3'd1;
  localparam logic [PREFIX_W-1:0] PREFIX_MAX   = 3'd4;
  localparam logic [PREFIX_W-1:0] PREFIX_RESET = 3'd4;

  // start code bytes
  localparam logic [BYTE_W-1:0] START_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] START_ONE  = 8'h01;

  // start code length and the phase of its final byte
  localparam int START_LEN = 4;
  localparam int PHASE_W   = $clog2(START_LEN);
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(START_LEN - 1);

  // command queue depth
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // what the back end has to emit for one accepted byte
  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_START = 2'd1,
    CMD_EMPTY = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [BYTE_W-1:0]  data;
    logic               done;
    logic               err;
    logic [BYTES_W-1:0] count;
  } cmd_t;

endpackage

`default_nettype wire

// ----- src/avcc_sample_to_annexb_core.sv -----
// top level: converts length-prefixed h.264 samples into start-code streams
// depends on a2ab_pkg, a2ab_front, a2ab_queue and a2ab_back
//
// usage
//   input channel: data_byte and sample_end under in_valid / in_stall; one
//   transfer per sample byte, sample_end on the final byte of the sample.
//   output channel: out_byte, byte_valid, run_last, sample_done,
//   overrun_error and bytes_written under out_valid / out_stall.
//   cfg_write loads cfg_data into the prefix size (reset 4); write it only
//   while the block is idle.
// data flow
//   a byte passes through the command queue and then the output register;
//   while out_stall is low, payload passes at one byte per cycle, the
//   length byte that completes a prefix yields four start code bytes as four
//   output transfers, and the output register issues one result per cycle.
// reset and stalls
//   rst (synchronous) clears the parser, the four-entry command queue and the
//   output valid flag; the prefix size returns to 4.
//   while out_stall is high the output holds; the queue keeps taking input
//   until it is full, then in_stall rises.
`default_nettype none

module avcc_sample_to_annexb_core
  import a2ab_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [PREFIX_W-1:0] cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [BYTE_W-1:0]   data_byte,
  input  wire logic                sample_end,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [BYTE_W-1:0]        out_byte,
  output logic                     byte_valid,
  output logic                     run_last,
  output logic                     sample_done,
  output logic                     overrun_error,
  output logic [BYTES_W-1:0]       bytes_written
);

  logic accept;
  logic push;
  logic pop;
  logic full;
  logic head_valid;
  cmd_t push_cmd;
  cmd_t head;

  // input transfer when the queue has room
  assign in_stall = full;
  assign accept   = in_valid && !full;

  a2ab_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .data_byte  (data_byte),
    .sample_end (sample_end),
    .push       (push),
    .cmd        (push_cmd)
  );

  a2ab_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  a2ab_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .run_last      (run_last),
    .sample_done   (sample_done),
    .overrun_error (overrun_error),
    .bytes_written (bytes_written)
  );

endmodule

`default_nettype wire

// ----- src/a2ab_front.sv -----
// front end: prefix parsing, payload tracking and byte counting per transfer
// depends on a2ab_pkg; produces one command per transfer that has a result
`default_nettype none

module a2ab_front
  import a2ab_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [PREFIX_W-1:0] cfg_data,
  input  wire logic                accept,
  input  wire logic [BYTE_W-1:0]   data_byte,
  input  wire logic                sample_end,
  output logic                     push,
  output cmd_t                     cmd
);

  logic [PREFIX_W-1:0]   prefix_bytes;
  logic                  in_payload, in_payload_next;
  logic [PREFIX_W-1:0]   prefix_count, prefix_count_next;
  logic [LEN_W-1:0]      remaining, remaining_next;
  logic [COUNT_BITS-1:0] written_total, written_total_next;

  logic [PREFIX_W-1:0]   size;
  logic [PREFIX_W-1:0]   pc_inc;
  logic [LEN_W-1:0]      rem_dec, rem_shift;
  logic [COUNT_BITS:0]   sum_one, sum_four;
  logic [COUNT_BITS-1:0] total_one, total_four;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_bytes <= PREFIX_RESET;
    end else if (cfg_write) begin
      prefix_bytes <= cfg_data;
    end
  end

  // out-of-range sizes fold onto the nearest legal one
  always_comb begin
    case (prefix_bytes) inside
      3'd0:          size = PREFIX_MIN;
      [3'd5:3'd7]:   size = PREFIX_MAX;
      default:       size = prefix_bytes;
    endcase
  end

  // candidate values
  assign pc_inc    = prefix_count + PREFIX_W'(1);
  assign rem_dec   = remaining - LEN_W'(1);
  assign rem_shift = {remaining[LEN_W-BYTE_W-1:0], data_byte};
  assign sum_one   = {1'b0, written_total} + (COUNT_BITS+1)'(1);
  assign sum_four  = {1'b0, written_total} + (COUNT_BITS+1)'(START_LEN);
  assign total_one  = sum_one[COUNT_BITS]  ? '1 : sum_one[COUNT_BITS-1:0];
  assign total_four = sum_four[COUNT_BITS] ? '1 : sum_four[COUNT_BITS-1:0];

  // classify the byte and work out the next state
  always_comb begin
    in_payload_next    = in_payload;
    prefix_count_next  = prefix_count;
    remaining_next     = remaining;
    written_total_next = written_total;
    push       = 1'b0;
    cmd.kind   = CMD_BYTE;
    cmd.data   = data_byte;
    cmd.done   = 1'b0;
    cmd.err    = 1'b0;
    cmd.count  = '0;
    if (accept) begin
      if (in_payload) begin
        push     = 1'b1;
        cmd.kind = CMD_BYTE;
        if (sample_end) begin
          cmd.done  = 1'b1;
          cmd.err   = (rem_dec != '0);
          cmd.count = BYTES_W'(total_one);
          in_payload_next    = 1'b0;
          prefix_count_next  = '0;
          remaining_next     = '0;
          written_total_next = '0;
        end else begin
          remaining_next     = rem_dec;
          written_total_next = total_one;
          if (rem_dec == '0) begin
            in_payload_next = 1'b0;
          end
        end
      end else if (pc_inc >= size) begin
        push              = 1'b1;
        prefix_count_next = '0;
        if (sample_end && rem_shift != '0) begin
          // length complete on the final byte: nal cannot follow
          cmd.kind  = CMD_EMPTY;
          cmd.data  = '0;
          cmd.done  = 1'b1;
          cmd.err   = 1'b1;
          cmd.count = BYTES_W'(written_total);
          in_payload_next    = 1'b0;
          remaining_next     = '0;
          written_total_next = '0;
        end else begin
          cmd.kind = CMD_START;
          cmd.data = '0;
          if (sample_end) begin
            cmd.done  = 1'b1;
            cmd.count = BYTES_W'(total_four);
            in_payload_next    = 1'b0;
            remaining_next     = '0;
            written_total_next = '0;
          end else begin
            remaining_next     = rem_shift;
            written_total_next = total_four;
            in_payload_next    = (rem_shift != '0);
          end
        end
      end else if (sample_end) begin
        // trailing partial prefix is dropped
        push      = 1'b1;
        cmd.kind  = CMD_EMPTY;
        cmd.data  = '0;
        cmd.done  = 1'b1;
        cmd.count = BYTES_W'(written_total);
        in_payload_next    = 1'b0;
        prefix_count_next  = '0;
        remaining_next     = '0;
        written_total_next = '0;
      end else begin
        remaining_next    = rem_shift;
        prefix_count_next = pc_inc;
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload    <= 1'b0;
      prefix_count  <= '0;
      remaining     <= '0;
      written_total <= '0;
    end else begin
      in_payload    <= in_payload_next;
      prefix_count  <= prefix_count_next;
      remaining     <= remaining_next;
      written_total <= written_total_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/a2ab_queue.sv -----
// short command queue between the front end and the back end
// depends on a2ab_pkg for the command type and depth
`default_nettype none

module a2ab_queue
  import a2ab_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output logic      full,
  output logic      head_valid,
  output cmd_t      head
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/a2ab_back.sv -----
// back end: expands commands into output bytes through an output register
// depends on a2ab_pkg; start codes take four output transfers
`default_nettype none

module a2ab_back
  import a2ab_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         head_valid,
  input  wire cmd_t         head,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              byte_valid,
  output logic              run_last,
  output logic              sample_done,
  output logic              overrun_error,
  output logic [BYTES_W-1:0] bytes_written
);

  logic [PHASE_W-1:0] phase;
  logic               load;
  logic               final_phase;

  // a start code needs four output transfers, everything else one
  assign final_phase = (head.kind != CMD_START) || (phase == PHASE_LAST);
  assign load        = head_valid && (!out_valid || !out_stall);
  assign pop         = load && final_phase;

  // start code beat counter
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (load) begin
      phase <= final_phase ? '0 : phase + PHASE_W'(1);
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      run_last      <= final_phase;
      sample_done   <= head.done && final_phase;
      overrun_error <= head.err && final_phase;
      bytes_written <= final_phase ? head.count : '0;
      case (head.kind)
        CMD_BYTE: begin
          out_byte   <= head.data;
          byte_valid <= 1'b1;
        end
        CMD_START: begin
          out_byte   <= (phase == PHASE_LAST) ? START_ONE : START_ZERO;
          byte_valid <= 1'b1;
        end
        default: begin
          out_byte   <= '0;
          byte_valid <= 1'b0;
        end
      endcase
    end
  end

  // only start code bytes can be followed by more results of the same transfer
  a_nonlast_is_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_last |-> byte_valid && !sample_done)
    else $error("non-final result without a byte");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_done |-> run_last)
    else $error("sample closed before the last result");

  a_err_needs_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && overrun_error |-> sample_done)
    else $error("overrun flagged on a result that does not close the sample");

  a_count_only_on_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sample_done |-> bytes_written == '0)
    else $error("byte count shown before the sample closes");

endmodule

`default_nettype wire

// ----- tb/sv/avcc_annexb_checker.sv -----
`timescale 1ns / 1ps
// checker for the length-prefix to start-code converter: watches both channels,
// predicts every output transfer and compares it; depends on a2ab_pkg
module avcc_annexb_checker
  import a2ab_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [PREFIX_W-1:0] cfg_data,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire logic [BYTE_W-1:0]   data_byte,
  input  wire logic                sample_end,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire logic [BYTE_W-1:0]   out_byte,
  input  wire logic                byte_valid,
  input  wire logic                run_last,
  input  wire logic                sample_done,
  input  wire logic                overrun_error,
  input  wire logic [BYTES_W-1:0]  bytes_written,
  output int                       fails,
  output int                       pending
);

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic               valid;
    logic               last;
    logic               done;
    logic               err;
    logic [BYTES_W-1:0] count;
  } annexb_word_t;

  localparam logic [63:0] COUNT_SAT = (64'd1 << COUNT_BITS) - 64'd1;

  // own copy of the prefix size and the parser state
  logic [PREFIX_W-1:0] prefix_size;
  logic                in_nal;
  logic [PREFIX_W-1:0] prefix_seen;
  logic [LEN_W-1:0]    nal_left;
  logic [BYTES_W-1:0]  sample_total;

  // output transfers still due, oldest first
  annexb_word_t annexb_due[$];

  function automatic void clear_sample();
    in_nal       = 1'b0;
    prefix_seen  = '0;
    nal_left     = '0;
    sample_total = '0;
  endfunction

  // saturating byte count of the current sample
  function automatic void add_count(input int unsigned n);
    logic [63:0] sum;
    sum = 64'(sample_total) + 64'(n);
    if (sum > COUNT_SAT) begin
      sum = COUNT_SAT;
    end
    sample_total = sum[BYTES_W-1:0];
  endfunction

  function automatic annexb_word_t annexb_word(input logic [BYTE_W-1:0] b, input logic valid,
                                               input logic done, input logic err);
    annexb_word_t w;
    w.data  = b;
    w.valid = valid;
    w.last  = 1'b0;
    w.done  = done;
    w.err   = err;
    w.count = done ? sample_total : '0;
    return w;
  endfunction

  // works out the output transfers caused by one input byte
  function automatic void predict_annexb(input logic [BYTE_W-1:0] b, input logic fin);
    logic [PREFIX_W-1:0] eff;
    logic [LEN_W-1:0]    len;
    annexb_word_t        res [START_LEN];
    int                  n;
    eff = prefix_size;
    if (eff < PREFIX_MIN) begin
      eff = PREFIX_MIN;
    end
    if (eff > PREFIX_MAX) begin
      eff = PREFIX_MAX;
    end
    n = 0;
    if (in_nal) begin
      // payload byte passes straight through
      nal_left = nal_left - 1;
      add_count(1);
      res[0] = annexb_word(b, 1'b1, fin, fin && (nal_left != 0));
      n = 1;
      if (fin) begin
        clear_sample();
      end else if (nal_left == 0) begin
        in_nal = 1'b0;
      end
    end else begin
      // gather big-endian length
      nal_left    = {nal_left[LEN_W-BYTE_W-1:0], b};
      prefix_seen = prefix_seen + 1'b1;
      if (prefix_seen >= eff) begin
        len         = nal_left;
        prefix_seen = '0;
        if (fin && len != 0) begin
          // declared nal cannot follow: error, no start code
          res[0] = annexb_word('0, 1'b0, 1'b1, 1'b1);
          n = 1;
          clear_sample();
        end else begin
          add_count(START_LEN);
          res[0] = annexb_word(START_ZERO, 1'b1, 1'b0, 1'b0);
          res[1] = res[0];
          res[2] = res[0];
          res[3] = annexb_word(START_ONE, 1'b1, fin, 1'b0);
          n = START_LEN;
          if (fin) begin
            clear_sample();
          end else if (len != 0) begin
            in_nal = 1'b1;
          end
        end
      end else if (fin) begin
        // partial trailing prefix is dropped
        res[0] = annexb_word('0, 1'b0, 1'b1, 1'b0);
        n = 1;
        clear_sample();
      end
    end
    for (int i = 0; i < n; i++) begin
      res[i].last = (i == n - 1);
      annexb_due.push_back(res[i]);
    end
  endfunction

  // follow configuration and input transfers, compare output transfers
  always @(posedge clk) begin : watch
    annexb_word_t got;
    annexb_word_t want;
    if (rst) begin
      prefix_size = PREFIX_RESET;
      clear_sample();
      annexb_due.delete();
      fails = 0;
    end else begin
      if (cfg_write) begin
        prefix_size = cfg_data;
      end
      if (in_valid && !in_stall) begin
        predict_annexb(data_byte, sample_end);
      end
      if (out_valid && !out_stall) begin
        got = {out_byte, byte_valid, run_last, sample_done, overrun_error, bytes_written};
        if (annexb_due.size() == 0) begin
          $display("%0t: unexpected transfer byte %02h valid %0b last %0b done %0b err %0b count %0d",
                   $time, got.data, got.valid, got.last, got.done, got.err, got.count);
          fails++;
        end else begin
          want = annexb_due.pop_front();
          if (got !== want) begin
            $display("%0t: expected byte %02h valid %0b last %0b done %0b err %0b count %0d",
                     $time, want.data, want.valid, want.last, want.done, want.err, want.count);
            $display("%0t: actual   byte %02h valid %0b last %0b done %0b err %0b count %0d",
                     $time, got.data, got.valid, got.last, got.done, got.err, got.count);
            fails++;
          end
        end
      end
    end
    pending <= annexb_due.size();
  end

endmodule

// ----- tb/sv/avcc_sample_to_annexb_core_tb.sv -----
`timescale 1ns / 1ps
// testbench top for avcc_sample_to_annexb_core: drives samples, stalls and the
// prefix size, gives the verdict; depends on a2ab_pkg and avcc_annexb_checker
module avcc_sample_to_annexb_core_tb;
  import a2ab_pkg::*;

  localparam int COUNT_W     = 16;
  localparam int LIMIT       = 1000000;
  localparam int DRAIN       = 8;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 90;

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic [PREFIX_W-1:0] cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic [BYTE_W-1:0]   data_byte;
  logic                sample_end;
  logic                out_valid;
  logic                out_stall;
  logic [BYTE_W-1:0]   out_byte;
  logic                byte_valid;
  logic                run_last;
  logic                sample_done;
  logic                overrun_error;
  logic [BYTES_W-1:0]  bytes_written;
  int                  fails;
  int                  pending;

  // sender state
  int                  send_idle_pct;
  int                  stall_pct;
  int                  hold_reqs;
  int                  sent_items;
  int                  cycles;
  logic [PREFIX_W-1:0] size_now;
  logic [8:0]          sample_bytes[$];

  avcc_sample_to_annexb_core #(
    .COUNT_BITS(COUNT_W)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .sample_end   (sample_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .run_last     (run_last),
    .sample_done  (sample_done),
    .overrun_error(overrun_error),
    .bytes_written(bytes_written)
  );

  avcc_annexb_checker #(
    .COUNT_BITS(COUNT_W)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .sample_end   (sample_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .run_last     (run_last),
    .sample_done  (sample_done),
    .overrun_error(overrun_error),
    .bytes_written(bytes_written),
    .fails        (fails),
    .pending      (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int held;
    held = 0;
    out_stall = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_reqs != held) begin
        held = hold_reqs;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // one input transfer, after an optional idle gap
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    sample_end <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_sample();
    logic [8:0] entry;
    while (sample_bytes.size() != 0) begin
      entry = sample_bytes.pop_front();
      send_byte(entry[BYTE_W-1:0], entry[8]);
    end
  endtask

  // stop offering and wait until every expected transfer has come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_prefix_size(input logic [PREFIX_W-1:0] v);
    size_now  = v;
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic int prefix_len(input logic [PREFIX_W-1:0] v);
    if (v < PREFIX_MIN) begin
      return PREFIX_MIN;
    end
    if (v > PREFIX_MAX) begin
      return PREFIX_MAX;
    end
    return v;
  endfunction

  // random sample: mostly well-formed nal units, some cut short, some with a
  // partial trailing prefix, a few pure noise; long forces one 50-byte nal
  function automatic void build_sample(input int eff, input logic long);
    int         nals;
    int         len;
    int         kind;
    int         keep;
    int         k;
    int         p;
    logic [8:0] tail;
    sample_bytes.delete();
    kind = long ? 99 : $urandom_range(99);
    nals = long ? 1 : $urandom_range(3, 1);
    if (kind < 5) begin
      repeat ($urandom_range(8, 1)) begin
        sample_bytes.push_back({($urandom_range(3) == 0), 8'($urandom)});
      end
    end else begin
      for (k = 0; k < nals; k++) begin
        len = long ? 50 : (($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6));
        for (p = eff - 1; p >= 0; p--) begin
          sample_bytes.push_back({1'b0, 8'(len >> (8 * p))});
        end
        repeat (len) sample_bytes.push_back({1'b0, 8'($urandom)});
      end
      if (kind < 15) begin
        if (eff > 1) begin
          repeat ($urandom_range(eff - 1, 1)) sample_bytes.push_back({1'b0, 8'($urandom)});
        end
      end else if (kind < 30) begin
        keep = $urandom_range(sample_bytes.size(), 1);
        while (sample_bytes.size() > keep) void'(sample_bytes.pop_back());
      end
    end
    tail    = sample_bytes.pop_back();
    tail[8] = 1'b1;
    sample_bytes.push_back(tail);
  endfunction

  initial begin : stimulus
    int phase;
    int phase_end;
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_data      = PREFIX_RESET;
    in_valid      = 1'b0;
    data_byte     = '0;
    sample_end    = 1'b0;
    send_idle_pct = 20;
    stall_pct     = 88;
    hold_reqs     = 0;
    sent_items    = 0;
    size_now      = PREFIX_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sample of a bare partial prefix, then a shorter prefix size
    sample_bytes = '{9'h000, 9'h000, 9'h000};
    send_sample();
    settle();
    write_prefix_size(3'd2);
    sample_bytes = '{9'h003, 9'h0a5, 9'h05a, 9'h1c3};
    send_sample();
    // sample ends inside payload; trailing partial prefix
    sample_bytes = '{9'h000, 9'h003, 9'h011, 9'h122};
    send_sample();
    sample_bytes = '{9'h000, 9'h001, 9'h080, 9'h17f};
    send_sample();
    settle();
    // smallest prefix: zero-length nal mid-sample and on the final byte,
    // then a prefix completing on the final byte with a nonzero length
    write_prefix_size(3'd1);
    sample_bytes = '{9'h001, 9'h0ff, 9'h000, 9'h100};
    send_sample();
    sample_bytes = '{9'h105};
    send_sample();
    settle();
    // out-of-range sizes act as the nearest limit
    write_prefix_size(3'd0);
    sample_bytes = '{9'h002, 9'h001, 9'h1fe};
    send_sample();
    settle();
    write_prefix_size(3'd7);
    sample_bytes = '{9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff, 9'h100};
    send_sample();

    // random samples under three idling patterns
    for (phase = 0; phase < 3; phase++) begin
      settle();
      case (phase)
        0: begin
          send_idle_pct = 20;
          stall_pct     <= 88;
          write_prefix_size(3'd3);
        end
        1: begin
          send_idle_pct = 88;
          stall_pct     <= 20;
          write_prefix_size(3'd5);
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     <= 0;
          write_prefix_size(3'd6);
        end
      endcase
      phase_end = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end) begin
        if ($urandom_range(4) == 0) begin
          settle();
          write_prefix_size(3'($urandom_range(7)));
        end
        build_sample(prefix_len(size_now), 1'b0);
        send_sample();
      end
    end

    // long receiver hold-off while the sender keeps going
    hold_reqs <= hold_reqs + 1;
    build_sample(prefix_len(size_now), 1'b1);
    send_sample();

    settle();
    if (fails == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
